/* hdl/htmp_pkg.sv */
// package for the half-time migration picker: item types, field widths
// and parameter defaults
// no dependencies
package htmp_pkg;

   // fixed field widths of the item ports
   localparam int unsigned TIME_W     = 48;
   localparam int unsigned CORE_W     = 3;
   localparam int unsigned TASK_NUM_W = 8;
   localparam int unsigned MASK_W     = 8;

   // parameter defaults for the top level
   localparam int unsigned NUM_CORES_DEF  = 8;
   localparam int unsigned TASK_SLOTS_DEF = 64;
   localparam int unsigned TIME_BITS_DEF  = 48;

   typedef struct packed {
      logic [TIME_W-1:0]     now_time;
      logic [CORE_W-1:0]     core_index;
      logic                  task_present;
      logic [TASK_NUM_W-1:0] task_number;
      logic [MASK_W-1:0]     active_mask;
      logic                  first_of_pass;
   } req_type;

   typedef struct packed {
      logic              migrate_valid;
      logic [CORE_W-1:0] from_core;
      logic [CORE_W-1:0] to_core;
      logic              no_free_core;
      logic              task_out_of_range;
   } rsp_type;

endpackage

/* hdl/half_time_migration_picker_core.sv */
// the stage 1 register holds the item for the table read and decision; the output register drives rsp_valid
// throughput: one item per cycle while req_stall is low; a flag read-modify-write per item with a forward path
// the migrated/seen flag memory is the limiting unit, one read and one write port
// reset: synchronous, active high; clears control state and the targeted mask,
// then a clear pass zeroes the flag rows in turn while req_stall is high
// start time memory is not cleared; its entries are only used after being written
module half_time_migration_picker_core #(
   parameter int unsigned NUM_CORES  = htmp_pkg::NUM_CORES_DEF,
   parameter int unsigned TASK_SLOTS = htmp_pkg::TASK_SLOTS_DEF,
   parameter int unsigned TIME_BITS  = htmp_pkg::TIME_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  htmp_pkg::req_type        req_item,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output htmp_pkg::rsp_type        rsp_item,
   // configuration: expected task duration
   input  logic                     csr_wr_en,
   input  logic [htmp_pkg::TIME_W-1:0] csr_wr_data
);
   import htmp_pkg::*;

   // derived sizes
   localparam int unsigned LIM        = (NUM_CORES < MASK_W) ? NUM_CORES : MASK_W;
   localparam int unsigned PAIR_COUNT = TASK_SLOTS * NUM_CORES;
   localparam int unsigned PAIR_W     = $clog2(PAIR_COUNT);
   localparam int unsigned TASK_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int unsigned ROW_W      = 2 * MASK_W;
   localparam logic [MASK_W-1:0] LIM_MASK = MASK_W'((1 << LIM) - 1);
   localparam logic [TASK_W-1:0] LAST_ROW = TASK_W'(TASK_SLOTS - 1);
   localparam logic [TASK_NUM_W:0] SLOT_LIMIT = (TASK_NUM_W + 1)'(TASK_SLOTS);

   // pair index into the start time table: task * NUM_CORES + core
   function automatic logic [PAIR_W-1:0] pair_addr(input logic [TASK_W-1:0] task_ix,
                                                   input logic [CORE_W-1:0] core);
      pair_addr = PAIR_W'(PAIR_W'(task_ix) * PAIR_W'(NUM_CORES) + PAIR_W'(core));
   endfunction

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [TIME_W-1:0] duration_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= '0;
      end else if (csr_wr_en) begin
         duration_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // clear pass over the flag rows after reset
   // ------------------------------------------------------------------
   logic              clr_busy_ff;
   logic [TASK_W-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_ROW) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // handshake and stage control
   // ------------------------------------------------------------------
   logic    s1_vld_ff;
   req_type s1_item_ff;
   logic    out_vld_ff;
   rsp_type out_item_ff;
   logic    s1_go;
   logic    s1_fire;
   logic    req_fire;

   // stage 1 moves on when the output register is empty or being drained
   assign s1_go     = !out_vld_ff || !rsp_stall;
   assign s1_fire   = s1_vld_ff && s1_go;
   // the next item enters whenever no clear pass runs and stage 1 is empty or moving on
   assign req_stall = clr_busy_ff || (s1_vld_ff && !s1_go);
   assign req_fire  = req_valid && !req_stall;

   // incoming item addresses for the memory reads
   logic [TASK_W-1:0] req_task_ix;
   logic [PAIR_W-1:0] req_pair;

   assign req_task_ix = req_item.task_number[TASK_W-1:0];
   assign req_pair    = pair_addr(req_task_ix, req_item.core_index);

   // ------------------------------------------------------------------
   // stage 1 decision logic
   // ------------------------------------------------------------------
   logic [MASK_W-1:0]    tmask_ff;
   logic [ROW_W-1:0]     rd_row_ff;
   logic [TIME_BITS-1:0] rd_start_ff;
   logic                 fwd_row_hit_ff;
   logic [ROW_W-1:0]     fwd_row_ff;
   logic                 fwd_start_hit_ff;
   logic [TIME_BITS-1:0] fwd_start_ff;

   logic [TASK_W-1:0]    s1_task_ix;
   logic [PAIR_W-1:0]    s1_pair;
   logic [CORE_W-1:0]    s1_core;
   logic [MASK_W-1:0]    core_oh;
   logic [MASK_W-1:0]    tmask_eff;
   logic                 out_of_range;
   logic                 act;
   logic [ROW_W-1:0]     row_eff;
   logic [MASK_W-1:0]    seen_v;
   logic [MASK_W-1:0]    mig_v;
   logic                 seen;
   logic                 migrated;
   logic [63:0]          now_ext;
   logic [TIME_BITS-1:0] now_tb;
   logic [TIME_BITS-1:0] start_eff;
   logic [TIME_BITS-1:0] elapsed;
   logic [TIME_W-1:0]    threshold;
   logic                 reached;
   logic [MASK_W-1:0]    free_v;
   logic                 found;
   logic [CORE_W-1:0]    pick;
   logic                 migrate;
   logic [MASK_W-1:0]    seen_new;
   logic [MASK_W-1:0]    mig_new;
   logic [ROW_W-1:0]     row_new;
   logic                 row_we;
   logic                 start_we;
   logic [MASK_W-1:0]    tmask_in;
   rsp_type              rsp_in;

   assign s1_task_ix = s1_item_ff.task_number[TASK_W-1:0];
   assign s1_pair    = pair_addr(s1_task_ix, s1_item_ff.core_index);
   assign s1_core    = s1_item_ff.core_index;
   assign core_oh    = MASK_W'(1) << s1_core;

   // a new pass reloads the targeted set before the item is looked at
   assign tmask_eff  = s1_item_ff.first_of_pass ? s1_item_ff.active_mask : tmask_ff;

   assign out_of_range = s1_item_ff.task_present &&
                         ({1'b0, s1_item_ff.task_number} >= SLOT_LIMIT);
   // the item only counts for a present, in-range task on an active core
   assign act = s1_item_ff.task_present && !out_of_range &&
                LIM_MASK[s1_core] && s1_item_ff.active_mask[s1_core];

   // flags row: the previous item may have written it at our read edge
   assign row_eff  = fwd_row_hit_ff ? fwd_row_ff : rd_row_ff;
   assign seen_v   = row_eff[MASK_W-1:0];
   assign mig_v    = row_eff[ROW_W-1:MASK_W];
   assign seen     = seen_v[s1_core];
   assign migrated = seen && mig_v[s1_core];

   // time is kept modulo 2^TIME_BITS
   assign now_ext   = 64'(s1_item_ff.now_time);
   assign now_tb    = now_ext[TIME_BITS-1:0];
   // first sighting starts the clock now, so elapsed is zero
   assign start_eff = !seen ? now_tb : (fwd_start_hit_ff ? fwd_start_ff : rd_start_ff);
   assign elapsed   = now_tb - start_eff;
   assign threshold = duration_ff >> 1;
   assign reached   = act && !migrated && (64'(elapsed) >= 64'(threshold));

   // free cores: inside the mask range, not targeted, not the source core
   assign free_v = ~tmask_eff & LIM_MASK & ~core_oh;
   assign found  = |free_v;

   // lowest-numbered free core
   always_comb begin
      pick = '0;
      for (int c = MASK_W - 1; c >= 0; c--) begin
         if (free_v[c]) begin
            pick = CORE_W'(c);
         end
      end
   end

   assign migrate = reached && found;

   // flag row update for this pair
   assign seen_new = seen_v | core_oh;
   assign mig_new  = (seen ? mig_v : (mig_v & ~core_oh)) | (migrate ? core_oh : '0);
   assign row_new  = {mig_new, seen_new};
   assign row_we   = s1_fire && act;
   assign start_we = s1_fire && act && !seen;

   assign tmask_in = tmask_eff | (migrate ? (MASK_W'(1) << pick) : '0);

   always_comb begin
      rsp_in                   = '0;
      rsp_in.task_out_of_range = out_of_range;
      rsp_in.migrate_valid     = migrate;
      rsp_in.from_core         = migrate ? s1_core : '0;
      rsp_in.to_core           = migrate ? pick : '0;
      rsp_in.no_free_core      = reached && !found;
   end

   // ------------------------------------------------------------------
   // flag memory: one row of seen and migrated bits per task
   // ------------------------------------------------------------------
   logic [ROW_W-1:0]  flag_mem [TASK_SLOTS];
   logic              flag_we;
   logic [TASK_W-1:0] flag_wa;
   logic [ROW_W-1:0]  flag_wd;

   assign flag_we = clr_busy_ff || row_we;
   assign flag_wa = clr_busy_ff ? clr_cnt_ff : s1_task_ix;
   assign flag_wd = clr_busy_ff ? '0 : row_new;

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      if (req_fire) begin
         rd_row_ff <= flag_mem[req_task_ix];
      end
   end

   // ------------------------------------------------------------------
   // start time memory: one entry per task and core pair
   // ------------------------------------------------------------------
   logic [TIME_BITS-1:0] start_mem [PAIR_COUNT];

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[s1_pair] <= now_tb;
      end
      if (req_fire) begin
         rd_start_ff <= start_mem[req_pair];
      end
   end

   // ------------------------------------------------------------------
   // stage 1 register, forward capture and targeted mask
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         tmask_ff  <= '0;
      end else begin
         if (req_fire) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_fire) begin
            tmask_ff <= tmask_in;
         end
      end
   end

   // payload and forward data need no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff       <= req_item;
         fwd_row_hit_ff   <= row_we && (s1_task_ix == req_task_ix);
         fwd_row_ff       <= row_new;
         fwd_start_hit_ff <= start_we && (s1_pair == req_pair);
         fwd_start_ff     <= now_tb;
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (s1_fire) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_item_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_item_ff;

`ifndef NO_ASSERTIONS
   // no item enters while the flag rows are being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> req_stall)
      else $error("item accepted during flag clear pass");

   // a migration and a no-free-core report never come together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.migrate_valid && rsp_item.no_free_core))
      else $error("migration and no free core both set");

   // a core never migrates to itself
   a_not_self: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.migrate_valid) |-> (rsp_item.to_core != rsp_item.from_core))
      else $error("migration target equals source");

   // the chosen target is marked as targeted after the item leaves stage 1
   a_target_marked: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && migrate) |=> tmask_ff[$past(pick)])
      else $error("migration target not marked in targeted set");

   // an out-of-range task produces no other result
   a_oor_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.task_out_of_range) |->
         (!rsp_item.migrate_valid && !rsp_item.no_free_core))
      else $error("out-of-range task produced a decision");
`endif

endmodule
